FILE: rtl/core/assert_macros.svh
// assertion macros used by the merge sorter datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// when pre holds, post must hold in the same cycle
`define ASSERT_IMPLIES(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

FILE: rtl/core/msort_pkg.sv
// shared constants and controller/datapath types for the merge sorter
`default_nettype none

package msort_pkg;

	localparam int SORT_DEPTH = 64;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = $clog2(SORT_DEPTH);
	localparam int CNT_W      = $clog2(SORT_DEPTH + 1);
	// two extra bits hold run bounds, which can pass the depth before clipping
	localparam int WIDE_W     = IDX_W + 2;

	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [WIDE_W-1:0] pos_t;

	typedef struct packed {
		logic load;
		logic start_sort;
		logic pass_end;
		logic run_init;
		logic merge_step;
		logic run_next;
		logic out_addr;
		logic out_load;
		logic out_next;
		logic clear_set;
	} cmd_t;

	typedef struct packed {
		logic width_lt_n;
		logic lo_lt_n;
		logic run_last;
		logic out_last;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/core/msort_in_if.sv
// input channel of the merge sorter: one value per transaction
`default_nettype none

interface msort_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [msort_pkg::DATA_W-1:0] value;
	logic                                last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink   (input valid, input value, input last_item, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/msort_out_if.sv
// output channel of the merge sorter: one sorted value per transaction
`default_nettype none

interface msort_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [msort_pkg::DATA_W-1:0] sorted_value;
	logic                                last_result;
	logic                                dropped;

	modport source (output valid, output sorted_value, output last_result, output dropped,
		input ready);
	modport sink   (input valid, input sorted_value, input last_result, input dropped,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/msort_ram.sv
// generic ram: one write port, two registered read ports
`default_nettype none

module msort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

FILE: rtl/core/msort_dp.sv
// merge sorter datapath: two ping-pong stores, run pointers, output register
`default_nettype none
`include "assert_macros.svh"

module msort_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire msort_pkg::cmd_t                     cmd,
	output msort_pkg::status_t                       status,
	input  wire logic signed [msort_pkg::DATA_W-1:0] value,
	output logic signed [msort_pkg::DATA_W-1:0]      sorted_value,
	output logic                                     last_result,
	output logic                                     dropped
);

	localparam int IDX_W  = msort_pkg::IDX_W;
	localparam int CNT_W  = msort_pkg::CNT_W;
	localparam int WIDE_W = msort_pkg::WIDE_W;

	msort_pkg::count_t count_q;
	msort_pkg::count_t out_idx_q;
	logic              ovf_q;
	logic              sel_q;   // store holding the current source runs: 0 = a, 1 = b
	msort_pkg::pos_t   width_q;
	msort_pkg::pos_t   lo_q;
	msort_pkg::pos_t   mid_q;
	msort_pkg::pos_t   hi_q;
	msort_pkg::pos_t   i_q;
	msort_pkg::pos_t   j_q;
	msort_pkg::pos_t   k_q;

	msort_pkg::pos_t   n_w;
	msort_pkg::pos_t   lw;
	msort_pkg::pos_t   l2w;
	msort_pkg::pos_t   mid_w;
	msort_pkg::pos_t   hi_w;
	logic              room;

	logic [IDX_W-1:0]  raddr_a;
	logic [IDX_W-1:0]  raddr_b;
	logic [IDX_W-1:0]  waddr_a;
	logic [msort_pkg::DATA_W-1:0] wdata_a;
	logic [msort_pkg::DATA_W-1:0] rda_a, rda_b, rdb_a, rdb_b;
	logic signed [msort_pkg::DATA_W-1:0] head_i, head_j, din;
	logic              take_i;
	logic              we_a, we_b;

	assign n_w   = {{(WIDE_W-CNT_W){1'b0}}, count_q};
	assign lw    = lo_q + width_q;
	assign l2w   = lo_q + {width_q[WIDE_W-2:0], 1'b0};
	assign mid_w = (lw < n_w) ? lw : n_w;
	assign hi_w  = (l2w < n_w) ? l2w : n_w;
	assign room  = count_q < CNT_W'(msort_pkg::SORT_DEPTH);

	assign raddr_a = cmd.out_addr ? out_idx_q[IDX_W-1:0] : i_q[IDX_W-1:0];
	assign raddr_b = j_q[IDX_W-1:0];

	assign head_i = sel_q ? rdb_a : rda_a;
	assign head_j = sel_q ? rdb_b : rda_b;

	// an exhausted side loses; the tail run of a pass may have an empty right side
	assign take_i = (i_q < mid_q) && (!(j_q < hi_q) || (head_i < head_j));
	assign din    = take_i ? head_i : head_j;

	assign we_a    = (cmd.load && room) || (cmd.merge_step && sel_q);
	assign we_b    = cmd.merge_step && !sel_q;
	assign waddr_a = cmd.load ? count_q[IDX_W-1:0] : k_q[IDX_W-1:0];
	assign wdata_a = cmd.load ? value : din;

	msort_ram #(
		.WIDTH (msort_pkg::DATA_W),
		.DEPTH (msort_pkg::SORT_DEPTH)
	) u_store_a (
		.clk     (clk),
		.we      (we_a),
		.waddr   (waddr_a),
		.wdata   (wdata_a),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rda_a),
		.rdata_b (rda_b)
	);

	msort_ram #(
		.WIDTH (msort_pkg::DATA_W),
		.DEPTH (msort_pkg::SORT_DEPTH)
	) u_store_b (
		.clk     (clk),
		.we      (we_b),
		.waddr   (k_q[IDX_W-1:0]),
		.wdata   (din),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdb_a),
		.rdata_b (rdb_b)
	);

	always_comb begin
		status.width_lt_n = width_q < n_w;
		status.lo_lt_n    = lo_q < n_w;
		status.run_last   = (k_q + WIDE_W'(1)) == hi_q;
		status.out_last   = (out_idx_q + CNT_W'(1)) == count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			out_idx_q <= '0;
			ovf_q     <= 1'b0;
			sel_q     <= 1'b0;
			width_q   <= '0;
			lo_q      <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
		end else begin
			if (cmd.load) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start_sort) begin
				width_q   <= WIDE_W'(1);
				lo_q      <= '0;
				sel_q     <= 1'b0;
				out_idx_q <= '0;
			end
			if (cmd.pass_end) begin
				width_q <= {width_q[WIDE_W-2:0], 1'b0};
				lo_q    <= '0;
				sel_q   <= !sel_q;
			end
			if (cmd.run_init) begin
				mid_q <= mid_w;
				hi_q  <= hi_w;
				i_q   <= lo_q;
				j_q   <= mid_w;
				k_q   <= lo_q;
			end
			if (cmd.merge_step) begin
				k_q <= k_q + WIDE_W'(1);
				if (take_i) begin
					i_q <= i_q + WIDE_W'(1);
				end else begin
					j_q <= j_q + WIDE_W'(1);
				end
			end
			if (cmd.run_next) begin
				lo_q <= l2w;
			end
			if (cmd.out_next) begin
				out_idx_q <= out_idx_q + CNT_W'(1);
			end
			if (cmd.clear_set) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sorted_value <= head_i;
			last_result  <= status.out_last;
			dropped      <= ovf_q;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(msort_pkg::SORT_DEPTH), "fill count past depth")
	`ASSERT_IMPLIES(a_merge_in_run, cmd.merge_step, (k_q < hi_q) && ((i_q < mid_q) || (j_q < hi_q)), "merge step outside run")
	`ASSERT_IMPLIES(a_out_in_set, cmd.out_load, out_idx_q < count_q, "output index past set")

endmodule

`default_nettype wire

FILE: rtl/core/msort_ctrl.sv
// merge sorter controller: load, merge passes and result sequencing
`default_nettype none

module msort_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_last,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire msort_pkg::status_t status,
	output msort_pkg::cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_PASS_CHK,
		S_RUN_CHK,
		S_READ,
		S_MERGE,
		S_OUT_READ,
		S_OUT_LOAD,
		S_OUT_WAIT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   valid_q;
	logic   in_acc;
	logic   out_acc;

	assign in_ready  = ready_q;
	assign out_valid = valid_q;
	assign in_acc    = in_valid && ready_q;
	assign out_acc   = valid_q && out_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_LOAD: begin
				cmd.load       = in_acc;
				cmd.start_sort = in_acc && in_last;
			end
			S_PASS_CHK: begin
			end
			S_RUN_CHK: begin
				cmd.run_init = status.lo_lt_n;
				cmd.pass_end = !status.lo_lt_n;
			end
			S_READ: begin
			end
			S_MERGE: begin
				cmd.merge_step = 1'b1;
				cmd.run_next   = status.run_last;
			end
			S_OUT_READ: begin
				cmd.out_addr = 1'b1;
			end
			S_OUT_LOAD: begin
				cmd.out_load = 1'b1;
			end
			S_OUT_WAIT: begin
				cmd.out_next  = out_acc;
				cmd.clear_set = out_acc && status.out_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ready_q <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc && in_last) begin
						state_q <= S_PASS_CHK;
						ready_q <= 1'b0;
					end
				end
				S_PASS_CHK: begin
					state_q <= status.width_lt_n ? S_RUN_CHK : S_OUT_READ;
				end
				S_RUN_CHK: begin
					state_q <= status.lo_lt_n ? S_READ : S_PASS_CHK;
				end
				S_READ: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					state_q <= status.run_last ? S_RUN_CHK : S_READ;
				end
				S_OUT_READ: begin
					state_q <= S_OUT_LOAD;
				end
				S_OUT_LOAD: begin
					state_q <= S_OUT_WAIT;
					valid_q <= 1'b1;
				end
				S_OUT_WAIT: begin
					if (out_acc) begin
						valid_q <= 1'b0;
						if (status.out_last) begin
							state_q <= S_LOAD;
							ready_q <= 1'b1;
						end else begin
							state_q <= S_OUT_READ;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/merge_sorter_unit.sv
// merge sorter top level: bottom-up merge sort of up to SORT_DEPTH signed values
//
// values channel: one signed 32-bit value per transaction; last_item closes the
//   set and starts the sort. values past SORT_DEPTH are discarded and flagged.
// sorted channel: the set in ascending order, one value per transaction, the
//   greatest marked by last_result; dropped is the same on every result of a set.
// ready stays high while loading and stays low from the closing
//   transaction until the last result of the set has been taken.
// sorting a set of n runs ceil(log2 n) passes between two ping-pong stores;
//   each value takes a read state for the registered store read and a merge
//   state (compare and write), each run a run check, and each pass a pass
//   check and a closing run check.
// each result then takes a store read, an output register load and the
//   handshake; the next result's read waits for that handshake.
// a stalled receiver holds the result register and the sequencer in place; no
//   result is lost or repeated.
// reset clears the fill count, overflow flag and sequencer; store contents
//   need no clearing since only entries written in the current set are read.
`default_nettype none

module merge_sorter_unit (
	input  wire logic    clk,
	input  wire logic    arst_n,
	msort_in_if.sink     values,
	msort_out_if.source  sorted
);

	msort_pkg::cmd_t    cmd;
	msort_pkg::status_t status;

	msort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (values.valid),
		.in_last   (values.last_item),
		.in_ready  (values.ready),
		.out_valid (sorted.valid),
		.out_ready (sorted.ready),
		.status    (status),
		.cmd       (cmd)
	);

	msort_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (values.value),
		.sorted_value (sorted.sorted_value),
		.last_result  (sorted.last_result),
		.dropped      (sorted.dropped)
	);

endmodule

`default_nettype wire

FILE: sim/tb_merge_sorter_unit.sv
// self-checking testbench for the merge sorter: directed and random sets under backpressure
`default_nettype none

module tb_merge_sorter_unit;

	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;

	typedef logic signed [msort_pkg::DATA_W-1:0] word_t;

	typedef struct {
		word_t sorted_value;
		logic  last_result;
		logic  dropped;
	} sorted_item_t;

	typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGES} spread_t;

	logic clk;
	logic arst_n;

	msort_in_if  values_ch ();
	msort_out_if sorted_ch ();

	merge_sorter_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.values (values_ch.sink),
		.sorted (sorted_ch.source)
	);

	// shadow of the sorter: values held in the open set and its overflow flag
	word_t        held_values[$];
	bit           overflow_pending;
	sorted_item_t sorted_exp_q[$];

	bit          steady_mode;
	bit          hold_requested;
	int unsigned hold_len;

	int mismatch_count;
	int values_sent;
	int sets_closed;
	int overflow_sets;
	int largest_set;
	int results_checked;
	int hold_stretches;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// holds a value and, when the set closes, queues the set in ascending order
	function automatic void predict_sorted_set(input word_t v, input bit closes);
		word_t        ordered[$];
		word_t        key;
		sorted_item_t item;
		int           j;
		if (held_values.size() < msort_pkg::SORT_DEPTH) begin
			held_values.push_back(v);
		end else begin
			overflow_pending = 1'b1;
		end
		if (!closes)
			return;
		ordered = held_values;
		for (int i = 1; i < ordered.size(); i++) begin
			key = ordered[i];
			j = i - 1;
			while (j >= 0 && ordered[j] > key) begin
				ordered[j + 1] = ordered[j];
				j--;
			end
			ordered[j + 1] = key;
		end
		foreach (ordered[k]) begin
			item.sorted_value = ordered[k];
			item.last_result  = (k == ordered.size() - 1);
			item.dropped      = overflow_pending;
			sorted_exp_q.push_back(item);
		end
		sets_closed++;
		if (overflow_pending)
			overflow_sets++;
		if (ordered.size() > largest_set)
			largest_set = ordered.size();
		held_values.delete();
		overflow_pending = 1'b0;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	// offers one value, waits for the transaction and updates the prediction
	task automatic send_value(input word_t v, input bit closes);
		while (!steady_mode && $urandom_range(99) < 13) begin
			values_ch.valid <= 1'b0;
			@(negedge clk);
		end
		values_ch.valid     <= 1'b1;
		values_ch.value     <= v;
		values_ch.last_item <= closes;
		@(posedge clk);
		while (!values_ch.ready)
			@(posedge clk);
		predict_sorted_set(v, closes);
		values_sent++;
		@(negedge clk);
	endtask

	function automatic word_t random_value(input spread_t spread);
		word_t edges[6];
		edges = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1, 32'sh8000_0001};
		case (spread)
			SPREAD_NARROW: return word_t'($urandom_range(15) - 8);
			SPREAD_EDGES:  return edges[$urandom_range(5)];
			default:       return word_t'($urandom);
		endcase
	endfunction

	task automatic send_set(input int n, input spread_t spread);
		for (int i = 0; i < n; i++)
			send_value(random_value(spread), i == n - 1);
	endtask

	task automatic send_list(input word_t vals[$]);
		foreach (vals[i])
			send_value(vals[i], i == vals.size() - 1);
	endtask

	// single values, pairs and equal values
	task automatic test_short_sets();
		send_list('{32'sh8000_0000});
		send_list('{32'sh7FFF_FFFF});
		send_list('{32'sh7FFF_FFFF, 32'sh8000_0000});
		send_list('{32'sh0, -32'sd1});
		send_list('{32'sd5, 32'sd5});
	endtask

	// extremes, alternating bit patterns, presorted and reversed input
	task automatic test_extreme_values();
		send_list('{32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000, -32'sd1, 32'sd1,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA});
		send_list('{-32'sd3, -32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2});
		send_list('{32'sd40, 32'sd7, 32'sd0, -32'sd7, -32'sd40});
	endtask

	// a full store, then sets that overflow, the closing value dropped too
	task automatic test_capacity();
		send_set(msort_pkg::SORT_DEPTH, SPREAD_WIDE);
		send_set(msort_pkg::SORT_DEPTH + 1, SPREAD_NARROW);
		send_set(msort_pkg::SORT_DEPTH + 3, SPREAD_WIDE);
		send_set(2, SPREAD_EDGES);
	endtask

	// receiver stalls long enough that the next set waits at the input
	task automatic test_receiver_hold();
		hold_len = 400;
		hold_requested = 1'b1;
		send_set(24, SPREAD_WIDE);
		send_set(8, SPREAD_NARROW);
	endtask

	task automatic test_steady_stream();
		steady_mode = 1'b1;
		send_set(9, SPREAD_WIDE);
		send_set(1, SPREAD_EDGES);
		send_set(17, SPREAD_NARROW);
		send_set(4, SPREAD_WIDE);
		steady_mode = 1'b0;
	endtask

	// mostly small sets with random content, now and then a longer one
	task automatic test_random_sets(input int budget);
		int n;
		int sent;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(9) == 0)
				n = $urandom_range(40, 13);
			else
				n = $urandom_range(12, 1);
			send_set(n, spread_t'($urandom_range(2)));
			sent += n;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		sorted_item_t want;
		if (arst_n && sorted_ch.valid && sorted_ch.ready) begin
			results_checked++;
			if (sorted_exp_q.size() == 0) begin
				flag_mismatch($sformatf("result %0d with no set pending",
					sorted_ch.sorted_value));
			end else begin
				want = sorted_exp_q.pop_front();
				if (sorted_ch.sorted_value !== want.sorted_value)
					flag_mismatch($sformatf("sorted_value expected %0d got %0d",
						want.sorted_value, sorted_ch.sorted_value));
				if (sorted_ch.last_result !== want.last_result)
					flag_mismatch($sformatf("last_result expected %b got %b (value %0d)",
						want.last_result, sorted_ch.last_result, want.sorted_value));
				if (sorted_ch.dropped !== want.dropped)
					flag_mismatch($sformatf("dropped expected %b got %b (value %0d)",
						want.dropped, sorted_ch.dropped, want.sorted_value));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		sorted_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requested) begin
				hold_left = hold_len;
				hold_requested = 1'b0;
				hold_stretches++;
			end
			if (hold_left > 0) begin
				hold_left--;
				sorted_ch.ready <= 1'b0;
			end else begin
				sorted_ch.ready <= steady_mode || ($urandom_range(99) >= 13);
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((values_ch.valid && values_ch.ready) || (sorted_ch.valid && sorted_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles, %0d results outstanding",
			$time, QUIET_LIMIT, sorted_exp_q.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		values_ch.valid = 1'b0;
		values_ch.value = '0;
		values_ch.last_item = 1'b0;
		overflow_pending = 1'b0;
		steady_mode = 1'b0;
		hold_requested = 1'b0;
		hold_len = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_short_sets();
		test_extreme_values();
		test_capacity();
		test_receiver_hold();
		test_steady_stream();
		test_random_sets(60);
		values_ch.valid <= 1'b0;

		while (sorted_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d values in %0d sets (%0d overflowed, largest %0d held)",
			values_sent, sets_closed, overflow_sets, largest_set);
		$display("checked %0d sorted results, %0d receiver hold-offs, %0d mismatches",
			results_checked, hold_stretches, mismatch_count);
		if (mismatch_count == 0 && sorted_exp_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/msort_pkg.sv
rtl/core/msort_in_if.sv
rtl/core/msort_out_if.sv
rtl/core/msort_ram.sv
rtl/core/msort_dp.sv
rtl/core/msort_ctrl.sv
rtl/core/merge_sorter_unit.sv
sim/tb_merge_sorter_unit.sv
